@@ sv/serial_command_decoder_event_queue_assert.svh @@
// ----------------------------------------------------------------------------
// Serial command decoder assertion macros
// Shorthand for the concurrent checks written at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_DECODER_EVENT_QUEUE_ASSERT_SVH
`define SERIAL_COMMAND_DECODER_EVENT_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCDEQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scdeq: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SCDEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scdeq: next-cycle check failed");

`endif

@@ sv/scdeq_pkg.sv @@
// ----------------------------------------------------------------------------
// scdeq_pkg
// Types, constants and character tables shared by the command decoder.
// ----------------------------------------------------------------------------
package scdeq_pkg;

	localparam int LINE_LIMIT_DEF = 64;
	localparam int RING_DEPTH_DEF = 16;

	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0D;

	localparam int PERIOD_FLAG = 4;

	typedef enum logic [2:0] {
		KIND_UART    = 3'd0,
		KIND_OLED    = 3'd1,
		KIND_TEMP    = 3'd2,
		KIND_MOIST   = 3'd3,
		KIND_PERIOD  = 3'd4,
		KIND_INVALID = 3'd5
	} line_kind_t;

	typedef struct packed {
		logic       ends;
		line_kind_t kind;
		logic [31:0] period;
		logic [31:0] reload;
	} line_rsp_t;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic [2:0] ev_code;
	} ring_req_t;

	typedef struct packed {
		logic       queued;
		logic [2:0] popped;
	} ring_rsp_t;

	localparam logic [7:0] TASK_TEXT [4][12] = '{
		'{"t", "a", "s", "k", ":", " ", "u", "a", "r", "t", ".", 8'h00},
		'{"t", "a", "s", "k", ":", " ", "o", "l", "e", "d", ".", 8'h00},
		'{"t", "a", "s", "k", ":", " ", "t", "e", "m", "p", ".", 8'h00},
		'{"t", "a", "s", "k", ":", " ", "m", "o", "i", "s", "t", "."}
	};
	localparam logic [7:0] TASK_LEN [4] = '{8'd11, 8'd11, 8'd11, 8'd12};

	localparam logic [7:0] PREFIX_TEXT [14] = '{
		"c", "h", "a", "n", "g", "e", "_", "p", "e", "r", "i", "o", "d", ":"
	};
	localparam logic [7:0] PREFIX_LEN = 8'd14;

	function automatic logic task_char_ok(input logic [1:0] idx, input logic [7:0] pos,
			input logic [7:0] c);
		logic ok;
		ok = 1'b0;
		if (pos < TASK_LEN[idx]) begin
			ok = (TASK_TEXT[idx][pos[3:0]] == c);
		end
		return ok;
	endfunction

	function automatic logic prefix_char_ok(input logic [7:0] pos, input logic [7:0] c);
		return PREFIX_TEXT[pos[3:0]] == c;
	endfunction

endpackage

@@ sv/serial_command_decoder_event_queue.sv @@
// ----------------------------------------------------------------------------
// serial_command_decoder_event_queue
// Decodes command lines from a serial byte stream, queues task events and
// answers pop requests from the event queue.
// ----------------------------------------------------------------------------
// Channel | Direction | Payload
// s_*     | in        | tdata: rx_byte; tuser: command
// m_*     | out       | tdata: line_kind, event_queued, period, reload, popped; tuser: kind
//
// One request is taken per cycle unless its result must wait for a held output register.
// Each request passes an input register, one decode stage and an output register.
// Non-command bytes that end no line move on while the output register is still held.
// Reset clears the line state and empties the event queue at once.
// ----------------------------------------------------------------------------
module serial_command_decoder_event_queue import scdeq_pkg::*; #(
	parameter int LINE_LIMIT = LINE_LIMIT_DEF,
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	input  logic        s_tuser,  // [0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // [2:0] line_kind, [3] event_queued, [35:4] period_value,
	                              // [67:36] reload_value, [70:68] popped_event, [71] zero
	output logic        m_tuser   // [0] result_kind
);

	logic       valid_s1;
	logic       command_s1;
	logic [7:0] rx_byte_s1;

	logic        valid_s2;
	logic [71:0] data_s2;
	logic        kind_s2;

	line_rsp_t line_rsp;
	ring_req_t ring_req;
	ring_rsp_t ring_rsp;

	logic has_result;
	logic out_free;
	logic fire;

	assign has_result = command_s1 || line_rsp.ends;
	assign out_free   = !valid_s2 || m_tready;
	assign fire       = valid_s1 && (!has_result || out_free);
	assign s_tready   = !valid_s1 || fire;

	scdeq_line_parser #(
		.LINE_LIMIT(LINE_LIMIT)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (fire && !command_s1),
		.rx_byte(rx_byte_s1),
		.rsp    (line_rsp)
	);

	always_comb begin
		ring_req.push    = fire && !command_s1 && line_rsp.ends
			&& (line_rsp.kind == KIND_UART || line_rsp.kind == KIND_OLED
			|| line_rsp.kind == KIND_TEMP || line_rsp.kind == KIND_MOIST);
		ring_req.pop     = fire && command_s1;
		ring_req.ev_code = line_rsp.kind + 3'd1;
	end

	scdeq_event_ring #(
		.RING_DEPTH(RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (ring_req),
		.rsp   (ring_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			command_s1 <= s_tuser;
			rx_byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire && has_result) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_result) begin
			kind_s2 <= command_s1;
			if (command_s1) begin
				data_s2 <= {1'b0, ring_rsp.popped, 32'd0, 32'd0, 1'b0, 3'd0};
			end else begin
				data_s2 <= {1'b0, 3'd0, line_rsp.reload, line_rsp.period, ring_rsp.queued,
					line_rsp.kind};
			end
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;
	assign m_tuser  = kind_s2;

`include "serial_command_decoder_event_queue_assert.svh"

	`SCDEQ_ASSERT_IMPLY(a_result_needs_slot, clk, arst_n, fire && has_result, out_free)
	`SCDEQ_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, s_tvalid && s_tready, valid_s1)
	`SCDEQ_ASSERT_IMPLY(a_queued_only_task, clk, arst_n, m_tvalid && m_tdata[3], !m_tuser && !m_tdata[2])
	`SCDEQ_ASSERT_IMPLY(a_reload_follows, clk, arst_n, m_tvalid && !m_tuser, m_tdata[67:36] == m_tdata[35:4] - 32'd1 || m_tdata[35:4] == 32'd0)

endmodule

@@ sv/scdeq_line_parser.sv @@
// ----------------------------------------------------------------------------
// scdeq_line_parser
// Matches one received character per step against the command words and
// accumulates the decimal period argument.
// ----------------------------------------------------------------------------
module scdeq_line_parser import scdeq_pkg::*; #(
	parameter int LINE_LIMIT = LINE_LIMIT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output line_rsp_t  rsp
);

	localparam int POS_W = $clog2(LINE_LIMIT);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_LIMIT - 1);

	typedef enum logic [1:0] {
		PH_BEFORE,
		PH_SIGN,
		PH_DIGITS,
		PH_AFTER
	} phase_t;

	logic [POS_W-1:0] pos_q;
	logic [4:0]       flags_q;
	phase_t           phase_q;
	logic             neg_q;
	logic [31:0]      acc_q;
	logic             sat_q;

	logic [4:0]  flags_n;
	phase_t      phase_n;
	logic        neg_n;
	logic [31:0] acc_n;
	logic        sat_n;
	logic        overflow;
	logic        ends;
	logic [7:0]  pos8;
	logic        is_digit;
	logic        is_space;
	logic        is_sign;
	logic        do_acc;
	logic [3:0]  digit_val;
	logic [35:0] prod;
	logic [31:0] value;
	line_kind_t  kind;

	assign pos8      = 8'(pos_q);
	assign overflow  = (pos_q >= POS_LAST);
	assign ends      = !overflow && (rx_byte == CHAR_DOT);
	assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
	assign is_space  = (rx_byte == CHAR_SPACE) || ((rx_byte >= CHAR_TAB) && (rx_byte <= CHAR_CR));
	assign is_sign   = (rx_byte == CHAR_PLUS) || (rx_byte == CHAR_MINUS);
	assign digit_val = 4'(rx_byte - CHAR_ZERO);
	assign prod      = (36'(acc_q) << 3) + (36'(acc_q) << 1) + 36'(digit_val);

	always_comb begin
		flags_n = flags_q;
		phase_n = phase_q;
		neg_n   = neg_q;
		do_acc  = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (!task_char_ok(2'(i), pos8, rx_byte)) begin
				flags_n[i] = 1'b0;
			end
		end
		if (pos8 < PREFIX_LEN) begin
			if (!prefix_char_ok(pos8, rx_byte)) begin
				flags_n[PERIOD_FLAG] = 1'b0;
			end
		end else if (flags_q[PERIOD_FLAG]) begin
			unique case (phase_q)
				PH_BEFORE: begin
					if (is_space) begin
						phase_n = PH_BEFORE;
					end else if (is_sign) begin
						neg_n   = (rx_byte == CHAR_MINUS);
						phase_n = PH_SIGN;
					end else if (!is_digit) begin
						flags_n[PERIOD_FLAG] = 1'b0;
					end else begin
						phase_n = PH_DIGITS;
						do_acc  = 1'b1;
					end
				end
				PH_SIGN: begin
					if (!is_digit) begin
						flags_n[PERIOD_FLAG] = 1'b0;
					end else begin
						phase_n = PH_DIGITS;
						do_acc  = 1'b1;
					end
				end
				PH_DIGITS: begin
					if (is_digit) begin
						do_acc = 1'b1;
					end else begin
						phase_n = PH_AFTER;
					end
				end
				PH_AFTER: begin
					phase_n = PH_AFTER;
				end
			endcase
		end
	end

	always_comb begin
		acc_n = acc_q;
		sat_n = sat_q;
		if (do_acc) begin
			if (prod[35:32] != 4'd0) begin
				sat_n = 1'b1;
			end else begin
				acc_n = prod[31:0];
			end
		end
	end

	always_comb begin
		priority if (flags_n[0]) begin
			kind = KIND_UART;
		end else if (flags_n[1]) begin
			kind = KIND_OLED;
		end else if (flags_n[2]) begin
			kind = KIND_TEMP;
		end else if (flags_n[3]) begin
			kind = KIND_MOIST;
		end else if (flags_n[PERIOD_FLAG] && (phase_n == PH_DIGITS || phase_n == PH_AFTER)) begin
			kind = KIND_PERIOD;
		end else begin
			kind = KIND_INVALID;
		end
	end

	assign value = sat_n ? 32'hFFFF_FFFF : (neg_n ? (32'd0 - acc_n) : acc_n);

	always_comb begin
		rsp.ends   = ends;
		rsp.kind   = kind;
		rsp.period = (kind == KIND_PERIOD) ? value : 32'd0;
		rsp.reload = (kind == KIND_PERIOD) ? (value - 32'd1) : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			flags_q <= '1;
			phase_q <= PH_BEFORE;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			sat_q   <= 1'b0;
		end else if (step) begin
			if (overflow || ends) begin
				pos_q   <= '0;
				flags_q <= '1;
				phase_q <= PH_BEFORE;
				neg_q   <= 1'b0;
				acc_q   <= '0;
				sat_q   <= 1'b0;
			end else begin
				pos_q   <= pos_q + 1'b1;
				flags_q <= flags_n;
				phase_q <= phase_n;
				neg_q   <= neg_n;
				acc_q   <= acc_n;
				sat_q   <= sat_n;
			end
		end
	end

endmodule

@@ sv/scdeq_event_ring.sv @@
// ----------------------------------------------------------------------------
// scdeq_event_ring
// Ring queue of task event codes with a registered head entry.
// ----------------------------------------------------------------------------
module scdeq_event_ring import scdeq_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ring_req_t req,
	output ring_rsp_t rsp
);

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

	logic [2:0] mem [RING_DEPTH];
	logic [2:0] head_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_inc;
	logic [PTR_W-1:0] wr_inc;
	logic [PTR_W-1:0] rd_n;
	logic [PTR_W-1:0] wr_n;
	logic push_ok;
	logic pop_ok;

	assign rd_inc  = (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
	assign wr_inc  = (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
	assign push_ok = req.push && (wr_inc != rd_q);
	assign pop_ok  = req.pop && (rd_q != wr_q);
	assign rd_n    = pop_ok ? rd_inc : rd_q;
	assign wr_n    = push_ok ? wr_inc : wr_q;

	assign rsp.queued = push_ok;
	assign rsp.popped = pop_ok ? head_q : 3'd0;

	// The head register always mirrors the entry at the next read pointer.
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[wr_q] <= req.ev_code;
		end
		if (push_ok && (wr_q == rd_n)) begin
			head_q <= req.ev_code;
		end else begin
			head_q <= mem[rd_n];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
		end else begin
			rd_q <= rd_n;
			wr_q <= wr_n;
		end
	end

endmodule
